[rtl/core/ttba_pkg.sv]
// Package for the tiled texture block address generator.
// Holds register indexes, field widths and the structs passed between stages.
// No dependencies.
package ttba_pkg;

  // Widest tiled surface the address math supports, in blocks.
  localparam int MAX_BLOCK_WIDTH = 8192;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_TILED_BLOCK_WIDTH    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TILED_BLOCK_HEIGHT   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ORIGINAL_BLOCK_WIDTH = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ORIGINAL_PIXEL_WIDTH = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_LOG_BYTES_PER_BLOCK  = 3'd4;

  localparam logic [13:0] MAX_BLOCK_WIDTH_W   = 14'(MAX_BLOCK_WIDTH);
  localparam logic [2:0]  LOG_BYTES_MAX       = 3'd4;
  localparam logic [15:0] PACKED_MIP_PIXEL_W  = 16'd16;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 88;

  // Effective configuration after saturation and clamping.
  typedef struct packed {
    logic [13:0] width;       // tiled width, saturated to the maximum
    logic [13:0] height;
    logic [13:0] orig_width;
    logic        mip_en;      // packed small-mip column offset applies
    logic [2:0]  lg;          // log2 bytes per block, clamped to four
  } cfg_t;

  // Payload of the product stage.
  typedef struct packed {
    logic [12:0] x;
    logic [12:0] y;
    logic [13:0] sx;          // source column after the mip offset
    logic        col_oor;
    logic [16:0] row_base;    // macro row times macro tiles per row
    logic [26:0] dest_prod;   // row times original width
    logic [27:0] area;        // tiled width times tiled height
  } prod_t;

  // Result item, first field in the highest bits.
  typedef struct packed {
    logic        index_out_of_range;
    logic        column_out_of_range;
    logic [29:0] dest_byte_offset;
    logic [29:0] source_byte_offset;
    logic [25:0] tiled_block_index;
  } result_t;

endpackage

[rtl/core/tiled_texture_block_address.sv]
// Top level of the tiled texture block address generator.
// Depends on ttba_pkg, ttba_cfg, ttba_prod and ttba_mix.
//
//   Channel   Direction  Payload                                       Handshake
//   s_*       in         dest_block_x, dest_block_y                    tvalid/tready
//   m_*       out        index, source/dest offsets, two range flags   tvalid/tready
//   cfg_*     in         register index and write data                 cfg_wen only
//
// Each request passes three register stages: an input register, a product
// register (the row product, the destination product and the surface area are
// the three multipliers) and the result register. A request is loaded into the input
// register when it is accepted, then moves to the product register and then to the
// result register. One request is taken every cycle while m_tready is high.
// Reset clears the stage valid bits and loads the default configuration.
// A stall on the result side holds each stage only while the stage behind it
// is full; bubbles are squeezed out, so the input keeps flowing into empty stages.
module tiled_texture_block_address import ttba_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // Configuration write port.
  input  logic                   cfg_wen,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // Block coordinate requests.
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_DATA_W-1:0]   s_tdata,   // [12:0] dest_block_x, [25:13] dest_block_y, zero
  // Address results.
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_DATA_W-1:0]  m_tdata    // [25:0] tiled_block_index,
                                            // [55:26] source_byte_offset,
                                            // [85:56] dest_byte_offset,
                                            // [86] column_out_of_range,
                                            // [87] index_out_of_range
);

  cfg_t    cfg;
  logic    prod_valid;
  logic    prod_ready;
  prod_t   prod_data;
  result_t result;

  // Register file; the datapath sees the saturated width and clamped log size.
  ttba_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register, source column with the packed mip offset, and products.
  ttba_prod u_prod (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_x      (s_tdata[12:0]),
    .in_y      (s_tdata[25:13]),
    .out_valid (prod_valid),
    .out_ready (prod_ready),
    .out_data  (prod_data)
  );

  // Macro/micro bit interleave, byte offsets and range checks.
  ttba_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .lg        (cfg.lg),
    .in_valid  (prod_valid),
    .in_ready  (prod_ready),
    .in_data   (prod_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (result)
  );

  assign m_tdata = result;

endmodule

[rtl/core/ttba_cfg.sv]
// Configuration registers of the tiled texture block address generator.
// Depends on ttba_pkg; derives the effective settings used by the datapath.
module ttba_cfg import ttba_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wen,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  logic [13:0] tiled_block_width;
  logic [13:0] tiled_block_height;
  logic [13:0] original_block_width;
  logic [15:0] original_pixel_width;
  logic [2:0]  log_bytes_per_block;
  logic [13:0] width_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      tiled_block_width    <= 14'd32;
      tiled_block_height   <= 14'd32;
      original_block_width <= 14'd32;
      original_pixel_width <= 16'd128;
      log_bytes_per_block  <= 3'd3;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_TILED_BLOCK_WIDTH:    tiled_block_width    <= cfg_data[13:0];
        REG_TILED_BLOCK_HEIGHT:   tiled_block_height   <= cfg_data[13:0];
        REG_ORIGINAL_BLOCK_WIDTH: original_block_width <= cfg_data[13:0];
        REG_ORIGINAL_PIXEL_WIDTH: original_pixel_width <= cfg_data;
        REG_LOG_BYTES_PER_BLOCK:  log_bytes_per_block  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign width_sat = (tiled_block_width > MAX_BLOCK_WIDTH_W) ? MAX_BLOCK_WIDTH_W
                                                             : tiled_block_width;

  always_comb begin
    cfg.width      = width_sat;
    cfg.height     = tiled_block_height;
    cfg.orig_width = original_block_width;
    // The mip offset needs room for two original widths side by side.
    cfg.mip_en     = ({1'b0, width_sat} >= {original_block_width, 1'b0}) &&
                     (original_pixel_width == PACKED_MIP_PIXEL_W);
    cfg.lg         = (log_bytes_per_block > LOG_BYTES_MAX) ? LOG_BYTES_MAX
                                                           : log_bytes_per_block;
  end

endmodule

[rtl/core/ttba_prod.sv]
// Input register and product stage of the tiled texture block address generator.
// Depends on ttba_pkg; forms the source column and the three products.
module ttba_prod import ttba_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [12:0] in_x,
  input  logic [12:0] in_y,
  output logic        out_valid,
  input  logic        out_ready,
  output prod_t       out_data
);

  logic        in_vld;
  logic [12:0] x_reg;
  logic [12:0] y_reg;
  logic        prod_vld;
  prod_t       prod;
  prod_t       prod_next;
  logic        in_stage_ready;
  logic        prod_stage_ready;
  logic [14:0] sx_sum;
  logic [13:0] aligned_sum;
  logic [8:0]  macro_cols;

  assign prod_stage_ready = !prod_vld || out_ready;
  assign in_stage_ready   = !in_vld || prod_stage_ready;
  assign in_ready         = in_stage_ready;
  assign out_valid        = prod_vld;
  assign out_data         = prod;

  always_comb begin
    sx_sum      = {2'b00, x_reg} + (cfg.mip_en ? {1'b0, cfg.orig_width} : 15'd0);
    // Width rounded up to 32 blocks, counted in macro tiles.
    aligned_sum = cfg.width + 14'd31;
    macro_cols  = aligned_sum[13:5];

    prod_next.x         = x_reg;
    prod_next.y         = y_reg;
    // With the offset on, the original width is at most half the tiled width.
    prod_next.sx        = sx_sum[13:0];
    prod_next.col_oor   = sx_sum[13:0] >= cfg.width;
    prod_next.row_base  = {9'd0, y_reg[12:5]} * {8'd0, macro_cols};
    prod_next.dest_prod = {14'd0, y_reg} * {13'd0, cfg.orig_width};
    prod_next.area      = {14'd0, cfg.width} * {14'd0, cfg.height};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld   <= 1'b0;
      prod_vld <= 1'b0;
    end else begin
      if (in_stage_ready) begin
        in_vld <= in_valid;
      end
      if (prod_stage_ready) begin
        prod_vld <= in_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_stage_ready && in_valid) begin
      x_reg <= in_x;
      y_reg <= in_y;
    end
    if (prod_stage_ready && in_vld) begin
      prod <= prod_next;
    end
  end

endmodule

[rtl/core/ttba_mix.sv]
// Bit mixing and result register of the tiled texture block address generator.
// Depends on ttba_pkg; turns the product stage payload into a result item.
module ttba_mix import ttba_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic [2:0] lg,
  input  logic    in_valid,
  output logic    in_ready,
  input  prod_t   in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic        res_vld;
  result_t     res;
  result_t     res_next;
  logic [17:0] macro_base;
  logic [33:0] macro;
  logic [9:0]  micro;
  logic [33:0] off;
  logic [1:0]  bank;
  logic [33:0] mixed;
  logic [33:0] idx;
  logic [33:0] src_full;
  logic [27:0] dest_sum;
  logic [31:0] dest_full;

  assign in_ready  = !res_vld || out_ready;
  assign out_valid = res_vld;
  assign out_data  = res;

  always_comb begin
    macro_base = {9'd0, in_data.sx[13:5]} + {1'b0, in_data.row_base};
    macro      = {16'd0, macro_base} << (4'(lg) + 4'd7);
    micro      = {4'd0, in_data.y[3:1], in_data.sx[2:0]} << lg;
    // Micro offset: bits above the low nibble spread by one bit, row parity at bit four.
    off        = macro
               + {23'd0, micro[9:4], 5'd0}
               + {30'd0, micro[3:0]}
               + {29'd0, in_data.y[0], 4'd0};
    bank       = {in_data.y[3], 1'b0} + in_data.sx[4:3];
    mixed      = {off[30:9], 12'd0}
               + {22'd0, in_data.y[4], 11'd0}
               + {23'd0, off[8:6], 8'd0}
               + {26'd0, bank, 6'd0}
               + {28'd0, off[5:0]};
    idx        = mixed >> lg;
    src_full   = idx << lg;
    dest_sum   = {1'b0, in_data.dest_prod} + {15'd0, in_data.x};
    dest_full  = {4'd0, dest_sum} << lg;

    res_next.tiled_block_index   = idx[25:0];
    res_next.source_byte_offset  = src_full[29:0];
    res_next.dest_byte_offset    = dest_full[29:0];
    res_next.column_out_of_range = in_data.col_oor;
    res_next.index_out_of_range  = idx >= {6'd0, in_data.area};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (in_ready) begin
      res_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      res <= res_next;
    end
  end

endmodule
